// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MSG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msg assertion failed");

// antecedent implies consequent in the next cycle
`define MSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msg assertion failed");

`endif

// ----- rtl/msg_pkg.sv -----
// shared widths, register indexes and constants of the momentum signal block
package msg_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 64;

    localparam int SYMBOL_W   = 16;
    localparam int PRICE_W    = 32;
    localparam int POS_W      = 32;
    localparam int QTY_W      = 32;
    localparam int LOOKBACK_W = 7;
    localparam int THRESH_W   = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SIZE = 3'd4;

    localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET  = 7'd16;
    localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 20'd1000;

    // return in centi basis points: diff * 1e6 against threshold * old
    localparam int PRICE_SCALE = 1000000;
    localparam int PROD_W      = 54;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

endpackage

// ----- rtl/msg_if.sv -----
// valid/ready channels for ticks and orders
interface msg_tick_if import msg_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [SYMBOL_W-1:0]        tick_symbol;
    logic [PRICE_W-1:0]         quote_mid;
    logic signed [POS_W-1:0]    position;

    modport source (output valid, output tick_symbol, output quote_mid, output position,
                    input ready);
    modport sink   (input valid, input tick_symbol, input quote_mid, input position,
                    output ready);
endinterface

interface msg_order_if import msg_pkg::*;;
    logic               valid;
    logic               ready;
    logic               order_side;
    logic [QTY_W-1:0]   order_quantity;

    modport source (output valid, output order_side, output order_quantity, input ready);
    modport sink   (input valid, input order_side, input order_quantity, output ready);
endinterface

// ----- rtl/momentum_signal_generator_unit.sv -----
// an order word passes stage 1, stage 2 and the output register after its tick is
// accepted; throughput: one tick per cycle when not stalled; the window memory takes
// one write and one registered read at the accept edge, products and compare follow
// in two stages; a waiting order word stops ticks only once all stages are full
// reset: configuration to defaults, write slot and fill count to zero, stage
// valid flags cleared; window memory is not cleared, the fill count guards it
module momentum_signal_generator_unit import msg_pkg::*; #(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    msg_tick_if.sink              tick,
    msg_order_if.source           order
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int NW = (CW > LOOKBACK_W) ? CW : LOOKBACK_W;

    // configuration
    logic [SYMBOL_W-1:0]   symbol_id_reg;
    logic                  enable_reg;
    logic [LOOKBACK_W-1:0] lookback_reg;
    logic [THRESH_W-1:0]   threshold_reg;
    logic [QTY_W-1:0]      entry_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_id_reg  <= '0;
            enable_reg     <= 1'b0;
            lookback_reg   <= LOOKBACK_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            entry_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYMBOL_ID:  symbol_id_reg  <= cfg_data[SYMBOL_W-1:0];
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_LOOKBACK:   lookback_reg   <= cfg_data[LOOKBACK_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THRESH_W-1:0];
                REG_ENTRY_SIZE: entry_size_reg <= cfg_data[QTY_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline flow
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_free, s2_free, s1_free, accept, take;

    assign out_free   = !out_valid_reg || order.ready;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign tick.ready = s1_free;
    assign accept     = tick.valid && s1_free;
    assign take       = accept && (tick.tick_symbol == symbol_id_reg) && enable_reg;

    // window bookkeeping
    logic [AW-1:0] write_slot_reg, write_slot_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [NW-1:0] lb_ext, n_eff;
    logic [AW-1:0] n_minus1, oldest_addr;
    logic          window_full, bypass;

    always_comb
    begin
        lb_ext = NW'(lookback_reg);
        if (lb_ext == '0)
            n_eff = NW'(1);
        else if (lb_ext > NW'(WINDOW_DEPTH))
            n_eff = NW'(WINDOW_DEPTH);
        else
            n_eff = lb_ext;
        n_minus1 = AW'(n_eff - NW'(1));
        bypass   = (n_eff == NW'(1));

        if (fill_count_reg < CW'(WINDOW_DEPTH))
            fill_count_next = fill_count_reg + CW'(1);
        else
            fill_count_next = fill_count_reg;
        window_full = (NW'(fill_count_next) >= n_eff);

        if (write_slot_reg == AW'(WINDOW_DEPTH - 1))
            write_slot_next = '0;
        else
            write_slot_next = write_slot_reg + AW'(1);

        // oldest price sits clamped lookback-1 slots behind the current one, modulo depth
        if (write_slot_reg >= n_minus1)
            oldest_addr = write_slot_reg - n_minus1;
        else
            oldest_addr = AW'((AW+1)'(write_slot_reg) + (AW+1)'(WINDOW_DEPTH)
                              - (AW+1)'(n_minus1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            fill_count_reg <= '0;
        end
        else if (take)
        begin
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // price window: one write, one registered read
    logic [PRICE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [PRICE_W-1:0] s1_old_reg;

    always_ff @(posedge clk)
    begin
        if (take)
            window_mem[write_slot_reg] <= tick.quote_mid;
        if (s1_free)
            s1_old_reg <= window_mem[oldest_addr];
    end

    // stage 1: tick fields beside the window read
    logic [PRICE_W-1:0] s1_mid_reg;
    logic               s1_bypass_reg, s1_flat_reg, s1_long_reg;
    logic [QTY_W-1:0]   s1_abs_reg;
    logic               pos_flat, pos_long;
    logic [POS_W-1:0]   pos_bits;

    assign pos_bits = tick.position;
    assign pos_flat = (pos_bits == '0);
    assign pos_long = !pos_flat && !pos_bits[POS_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= take && window_full;
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_mid_reg    <= tick.quote_mid;
            s1_bypass_reg <= bypass;
            s1_flat_reg   <= pos_flat;
            s1_long_reg   <= pos_long;
            s1_abs_reg    <= pos_long ? pos_bits : QTY_W'('0 - pos_bits);
        end
    end

    // stage 2: difference and the two products
    logic [PRICE_W-1:0]       old_price;
    logic signed [PRICE_W:0]  diff;
    logic signed [PROD_W-1:0] lhs_next, rhs_next;

    always_comb
    begin
        old_price = s1_bypass_reg ? s1_mid_reg : s1_old_reg;
        diff      = $signed({1'b0, s1_mid_reg}) - $signed({1'b0, old_price});
        lhs_next  = PROD_W'(diff) * PROD_W'(PRICE_SCALE);
        rhs_next  = $signed(PROD_W'(threshold_reg) * PROD_W'(old_price));
    end

    logic signed [PROD_W-1:0] s2_lhs_reg, s2_rhs_reg;
    logic                     s2_diff_neg_reg, s2_diff_pos_reg, s2_old_zero_reg;
    logic                     s2_flat_reg, s2_long_reg;
    logic [QTY_W-1:0]         s2_abs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_lhs_reg      <= lhs_next;
            s2_rhs_reg      <= rhs_next;
            s2_diff_neg_reg <= diff[PRICE_W];
            s2_diff_pos_reg <= !diff[PRICE_W] && (diff != '0);
            s2_old_zero_reg <= (old_price == '0);
            s2_flat_reg     <= s1_flat_reg;
            s2_long_reg     <= s1_long_reg;
            s2_abs_reg      <= s1_abs_reg;
        end
    end

    // decision into the output register
    logic             hit, side_next;
    logic [QTY_W-1:0] qty_next;

    always_comb
    begin
        hit       = 1'b0;
        side_next = SIDE_BUY;
        qty_next  = s2_abs_reg;
        if (s2_flat_reg)
        begin
            qty_next = entry_size_reg;
            if (s2_lhs_reg > s2_rhs_reg)
            begin
                hit       = 1'b1;
                side_next = SIDE_BUY;
            end
            else if (s2_lhs_reg < -s2_rhs_reg)
            begin
                hit       = 1'b1;
                side_next = SIDE_SELL;
            end
        end
        else if (s2_long_reg)
        begin
            hit       = s2_diff_neg_reg;
            side_next = SIDE_SELL;
        end
        else
        begin
            hit       = s2_diff_pos_reg;
            side_next = SIDE_BUY;
        end
        if (s2_old_zero_reg)
            hit = 1'b0;
    end

    logic             out_side_reg;
    logic [QTY_W-1:0] out_qty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_valid_reg && hit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_side_reg <= side_next;
            out_qty_reg  <= qty_next;
        end
    end

    assign order.valid          = out_valid_reg;
    assign order.order_side     = out_side_reg;
    assign order.order_quantity = out_qty_reg;

endmodule

// ----- rtl/msg_checker.sv -----
// port-level checks of the momentum signal block, bound into its module
`include "assert_macros.svh"

module msg_checker import msg_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             tick_ready,
    input logic             order_valid,
    input logic             order_ready,
    input logic             order_side,
    input logic [QTY_W-1:0] order_quantity
);

    // an order word waits until taken
    `MSG_ASSERT_NEXT(a_order_hold, order_valid && !order_ready, order_valid)

    // a waiting order word does not change
    `MSG_ASSERT_NEXT(a_order_stable, order_valid && !order_ready, $stable(order_side) && $stable(order_quantity))

    // with the output free the stages behind it are free too
    `MSG_ASSERT_SAME(a_ready_when_free, !order_valid || order_ready, tick_ready)

    // nothing leaves in the first cycle out of reset
    `MSG_ASSERT_SAME(a_quiet_after_reset, $past(!rst_n), !order_valid)

endmodule

bind momentum_signal_generator_unit msg_checker u_msg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_ready     (tick.ready),
    .order_valid    (order.valid),
    .order_ready    (order.ready),
    .order_side     (order.order_side),
    .order_quantity (order.order_quantity)
);
